FILE: hw/rtl/brd_pkg.sv
package brd_pkg;

	// Queue and literal limits.
	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_LITERAL_BITS = 16;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LCNT_W = $clog2(MAX_LITERAL_BITS + 1);

	// Fixed decoder constants.
	localparam logic [7:0] RANGE_INIT = 8'd255;
	localparam logic [7:0] PROB_HALF = 8'd128;
	localparam logic [3:0] BYTE_BITS_LEFT = 4'd7;

	// Item kinds.
	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_START = 2'd1,
		KIND_BOOL = 2'd2,
		KIND_LITERAL = 2'd3
	} kind_t;

	// Input word.
	typedef struct packed {
		kind_t kind;
		logic [7:0] data_byte;
		logic [7:0] prob;
		logic [4:0] literal_bits;
	} item_t;

	// Result word.
	typedef struct packed {
		logic [15:0] decoded_value;
		logic underrun;
		logic overflow;
	} result_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START_LO,
		ST_DECIDE,
		ST_NORM
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;
		logic load_hi;
		logic load_lo;
		logic capture;
		logic decide;
		logic norm;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic range_low;
		logic cnt_zero;
	} stat_t;

endpackage

FILE: hw/rtl/brd_queue.sv
module brd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [7:0] push_byte,
	input logic pop,
	output logic [7:0] head_byte,
	output logic empty,
	output logic underrun,
	output logic overflow
);

	logic [7:0] mem_q [brd_pkg::QUEUE_DEPTH];
	logic [brd_pkg::QPTR_W-1:0] head_q;
	logic [brd_pkg::QPTR_W-1:0] tail_q;
	logic [brd_pkg::QCNT_W-1:0] count_q;
	logic underrun_q;
	logic overflow_q;
	logic full;

	assign empty = (count_q == '0);
	assign full = (count_q == brd_pkg::QCNT_W'(brd_pkg::QUEUE_DEPTH));
	assign head_byte = mem_q[head_q];
	assign underrun = underrun_q;
	assign overflow = overflow_q;

	// Byte storage; entries hold garbage until written.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[tail_q] <= push_byte;
		end
	end

	// Pointers, fill count and sticky error flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			underrun_q <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			if (push) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					tail_q <= (tail_q == brd_pkg::QPTR_W'(brd_pkg::QUEUE_DEPTH - 1)) ?
						'0 : tail_q + 1'b1;
					count_q <= count_q + 1'b1;
				end
			end else if (pop) begin
				if (empty) begin
					underrun_q <= 1'b1;
				end else begin
					head_q <= (head_q == brd_pkg::QPTR_W'(brd_pkg::QUEUE_DEPTH - 1)) ?
						'0 : head_q + 1'b1;
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	// The fill count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= brd_pkg::QCNT_W'(brd_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	// A pop from an empty queue raises the underrun flag.
	a_underrun_set: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && empty) |=> underrun_q)
		else $error("underrun not flagged");

endmodule

FILE: hw/rtl/brd_datapath.sv
module brd_datapath (
	input logic clk,
	input logic arst_n,
	input brd_pkg::cmd_t cmd,
	input brd_pkg::item_t item,
	input logic [7:0] head_byte,
	input logic q_empty,
	input logic q_underrun,
	input logic q_overflow,
	output logic pop,
	output brd_pkg::stat_t stat,
	output brd_pkg::result_t result
);

	logic [7:0] range_q;
	logic [15:0] window_q;
	logic [7:0] shift_byte_q;
	logic [3:0] bits_left_q;
	logic [7:0] prob_q;
	logic [brd_pkg::LCNT_W-1:0] cnt_q;
	logic [15:0] acc_q;
	brd_pkg::result_t result_q;

	logic [7:0] fetch_byte;
	logic [15:0] product;
	logic [8:0] split;
	logic bit_one;
	logic refill;
	logic shift_in;
	logic [brd_pkg::LCNT_W-1:0] lit_cnt;

	// A missing byte reads as zero.
	assign fetch_byte = q_empty ? 8'd0 : head_byte;
	assign refill = (bits_left_q == 4'd0);
	assign pop = cmd.load_hi || cmd.load_lo || (cmd.norm && refill);
	assign shift_in = refill ? fetch_byte[7] : shift_byte_q[7];

	// Split point and bit decision.
	assign product = (range_q - 8'd1) * prob_q;
	assign split = {1'b0, product[15:8]} + 9'd1;
	assign bit_one = ({1'b0, window_q[15:8]} >= split);

	// Clamped literal length.
	always_comb begin
		if (32'(item.literal_bits) > brd_pkg::MAX_LITERAL_BITS) begin
			lit_cnt = brd_pkg::LCNT_W'(brd_pkg::MAX_LITERAL_BITS);
		end else begin
			lit_cnt = brd_pkg::LCNT_W'(item.literal_bits);
		end
	end

	assign stat.range_low = !range_q[7];
	assign stat.cnt_zero = (cnt_q == '0);
	assign result = result_q;

	// Range, value window and bit supply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= brd_pkg::RANGE_INIT;
			window_q <= '0;
			shift_byte_q <= '0;
			bits_left_q <= '0;
		end else begin
			if (cmd.load_hi) begin
				range_q <= brd_pkg::RANGE_INIT;
				window_q[15:8] <= fetch_byte;
				shift_byte_q <= '0;
				bits_left_q <= '0;
			end else if (cmd.load_lo) begin
				window_q[7:0] <= fetch_byte;
			end else if (cmd.decide) begin
				if (bit_one) begin
					range_q <= range_q - split[7:0];
					window_q[15:8] <= window_q[15:8] - split[7:0];
				end else begin
					range_q <= split[7:0];
				end
			end else if (cmd.norm) begin
				range_q <= {range_q[6:0], 1'b0};
				window_q <= {window_q[14:0], shift_in};
				if (refill) begin
					shift_byte_q <= {fetch_byte[6:0], 1'b0};
					bits_left_q <= brd_pkg::BYTE_BITS_LEFT;
				end else begin
					shift_byte_q <= {shift_byte_q[6:0], 1'b0};
					bits_left_q <= bits_left_q - 4'd1;
				end
			end
		end
	end

	// Per-item probability, bit count and assembled value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.capture) begin
			cnt_q <= (item.kind == brd_pkg::KIND_LITERAL) ? lit_cnt : brd_pkg::LCNT_W'(1);
		end else if (cmd.decide) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			prob_q <= (item.kind == brd_pkg::KIND_LITERAL) ? brd_pkg::PROB_HALF : item.prob;
			acc_q <= '0;
		end else if (cmd.decide) begin
			acc_q <= {acc_q[14:0], bit_one};
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.decoded_value <= acc_q;
			result_q.underrun <= q_underrun;
			result_q.overflow <= q_overflow;
		end
	end

	// The range never collapses to zero.
	a_range_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		range_q != 8'd0)
		else $error("range reached zero");

endmodule

FILE: hw/rtl/brd_ctrl.sv
module brd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input brd_pkg::kind_t kind,
	input logic result_ready,
	input brd_pkg::stat_t stat,
	output logic item_ready,
	output logic result_valid,
	output brd_pkg::cmd_t cmd
);

	brd_pkg::state_t state_q;
	brd_pkg::state_t state_d;
	logic out_valid_q;

	assign result_valid = out_valid_q;

	// State register and result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		item_ready = 1'b0;
		case (state_q)
			brd_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					case (kind)
						brd_pkg::KIND_PUSH: begin
							cmd.push = 1'b1;
						end
						brd_pkg::KIND_START: begin
							cmd.load_hi = 1'b1;
							state_d = brd_pkg::ST_START_LO;
						end
						default: begin
							cmd.capture = 1'b1;
							state_d = brd_pkg::ST_NORM;
						end
					endcase
				end
			end
			brd_pkg::ST_START_LO: begin
				cmd.load_lo = 1'b1;
				state_d = brd_pkg::ST_IDLE;
			end
			brd_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = brd_pkg::ST_NORM;
			end
			brd_pkg::ST_NORM: begin
				if (stat.range_low) begin
					cmd.norm = 1'b1;
				end else if (!stat.cnt_zero) begin
					state_d = brd_pkg::ST_DECIDE;
				end else if (!out_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_d = brd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = brd_pkg::ST_IDLE;
			end
		endcase
	end

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || result_ready))
		else $error("result overwritten");

endmodule

FILE: hw/rtl/boolean_range_decoder_unit.sv
// Boolean range decoder of the VP8/VP9 kind. Items arrive as words on the item channel: a push
// queues one compressed byte (16-entry queue), a start sets the range to 255 and loads the
// 16-bit value window from the next two queued bytes, a bool decode returns one bit for an 8-bit
// probability of zero, and a literal returns up to 16 bits decoded at probability one half,
// first bit in the most significant place. Only bool and literal items produce a result word,
// which carries the sticky underrun (zeros used for missing bytes) and overflow (push to a full
// queue dropped) flags as they stand after that item. One item is in work at a time. Every
// decoded bit costs a range check and a decision, and renormalization shifts the window one
// bit per cycle (0 to 7 shifts per bit) through a single shifter. A finished result waits in
// an output register while the next item is accepted, unless that item also finishes before
// it is taken.
module boolean_range_decoder_unit (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input brd_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output brd_pkg::result_t result
);

	brd_pkg::cmd_t cmd;
	brd_pkg::stat_t stat;
	logic pop;
	logic [7:0] head_byte;
	logic q_empty;
	logic q_underrun;
	logic q_overflow;

	// Sequencer.
	brd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.kind(item.kind),
		.result_ready(result_ready),
		.stat(stat),
		.item_ready(item_ready),
		.result_valid(result_valid),
		.cmd(cmd)
	);

	// Compressed byte queue.
	brd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd.push),
		.push_byte(item.data_byte),
		.pop(pop),
		.head_byte(head_byte),
		.empty(q_empty),
		.underrun(q_underrun),
		.overflow(q_overflow)
	);

	// Range arithmetic and result assembly.
	brd_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.item(item),
		.head_byte(head_byte),
		.q_empty(q_empty),
		.q_underrun(q_underrun),
		.q_overflow(q_overflow),
		.pop(pop),
		.stat(stat),
		.result(result)
	);

endmodule

FILE: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int TAIL_CYCLES = 200;
	localparam int RANDOM_ITEMS = 1300;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	brd_pkg::item_t item;
	logic result_valid;
	logic result_ready;
	brd_pkg::result_t result;

	// Shadow copy of the decoder state, advanced once per accepted word.
	logic [7:0] range_q;
	logic [15:0] window_q;
	logic [7:0] shift_byte_q;
	logic [3:0] shift_left_q;
	logic [7:0] byte_fifo [brd_pkg::QUEUE_DEPTH];
	int fifo_head;
	int fifo_tail;
	int fifo_count;
	logic underrun_q;
	logic overflow_q;

	brd_pkg::result_t expected_results [$];
	int error_count;
	int cycle_count;
	int items_sent;
	int hold_off;
	bit tx_gaps_on;
	bit rx_gaps_on;

	boolean_range_decoder_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Take the next queued byte, or a zero with the underrun flag when empty.
	function automatic logic [7:0] take_byte();
		logic [7:0] b;
		if (fifo_count == 0) begin
			underrun_q = 1'b1;
			return 8'd0;
		end
		b = byte_fifo[fifo_head];
		fifo_head = (fifo_head + 1) % brd_pkg::QUEUE_DEPTH;
		fifo_count--;
		return b;
	endfunction

	function automatic void store_byte(input logic [7:0] b);
		if (fifo_count >= brd_pkg::QUEUE_DEPTH) begin
			overflow_q = 1'b1;
			return;
		end
		byte_fifo[fifo_tail] = b;
		fifo_tail = (fifo_tail + 1) % brd_pkg::QUEUE_DEPTH;
		fifo_count++;
	endfunction

	// One arithmetic-decoded bit followed by renormalization.
	function automatic logic decode_bit(input logic [7:0] p);
		int split;
		int big;
		int g;
		logic b;
		split = 1 + (((int'(range_q) - 1) * int'(p)) >> 8);
		big = split << 8;
		if (int'(window_q) >= big) begin
			b = 1'b1;
			range_q = range_q - split[7:0];
			window_q = window_q - big[15:0];
		end else begin
			b = 1'b0;
			range_q = split[7:0];
		end
		for (g = 0; g < 8 && range_q < 8'd128; g++) begin
			if (shift_left_q == 4'd0) begin
				shift_byte_q = take_byte();
				shift_left_q = 4'd8;
			end
			range_q = range_q << 1;
			window_q = {window_q[14:0], shift_byte_q[7]};
			shift_byte_q = shift_byte_q << 1;
			shift_left_q--;
		end
		return b;
	endfunction

	// Apply one word to the shadow state; returns 1 when a result is due.
	function automatic bit predict_item(input brd_pkg::item_t w, output brd_pkg::result_t r);
		logic [7:0] hi;
		logic [7:0] lo;
		logic [15:0] v;
		int nb;
		r = '0;
		v = '0;
		case (w.kind)
			brd_pkg::KIND_PUSH: begin
				store_byte(w.data_byte);
				return 1'b0;
			end
			brd_pkg::KIND_START: begin
				range_q = brd_pkg::RANGE_INIT;
				hi = take_byte();
				lo = take_byte();
				window_q = {hi, lo};
				shift_byte_q = '0;
				shift_left_q = '0;
				return 1'b0;
			end
			brd_pkg::KIND_BOOL: begin
				v = {15'd0, decode_bit(w.prob)};
			end
			default: begin
				nb = (int'(w.literal_bits) > brd_pkg::MAX_LITERAL_BITS) ?
					brd_pkg::MAX_LITERAL_BITS : int'(w.literal_bits);
				for (int i = 0; i < nb; i++)
					v = {v[14:0], decode_bit(brd_pkg::PROB_HALF)};
			end
		endcase
		r.decoded_value = v;
		r.underrun = underrun_q;
		r.overflow = overflow_q;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < 100)
			$display("%0t ns: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin : result_check
		brd_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result word with none pending",
					int'(result.decoded_value), 0);
			end else begin
				want = expected_results.pop_front();
				if (result.decoded_value !== want.decoded_value)
					report_mismatch("decoded_value", int'(result.decoded_value),
						int'(want.decoded_value));
				if (result.underrun !== want.underrun)
					report_mismatch("underrun", int'(result.underrun),
						int'(want.underrun));
				if (result.overflow !== want.overflow)
					report_mismatch("overflow", int'(result.overflow),
						int'(want.overflow));
			end
		end
	end

	// Result side: random stalls, plus long hold-offs on request.
	initial begin : result_sink
		int stall;
		stall = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				result_ready = 1'b0;
				hold_off--;
			end else if (stall > 0) begin
				result_ready = 1'b0;
				stall--;
			end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
				result_ready = (stall == 0);
				if (stall > 0) stall--;
			end else begin
				result_ready = 1'b1;
			end
		end
	end

	// Offer one word after an optional gap and hold it until accepted.
	task automatic send_word(input brd_pkg::item_t w);
		int gap;
		brd_pkg::result_t want;
		gap = tx_gaps_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid = 1'b1;
		item = w;
		do @(posedge clk); while (!item_ready);
		if (predict_item(w, want)) expected_results.push_back(want);
		items_sent++;
	endtask

	// A word of the given kind with every other field random.
	function automatic brd_pkg::item_t random_word(input brd_pkg::kind_t k);
		brd_pkg::item_t w;
		w.kind = k;
		w.data_byte = 8'($urandom_range(0, 255));
		w.prob = 8'($urandom_range(0, 255));
		w.literal_bits = 5'($urandom_range(0, 31));
		return w;
	endfunction

	task automatic send_bool(input logic [7:0] p);
		brd_pkg::item_t w;
		w = random_word(brd_pkg::KIND_BOOL);
		w.prob = p;
		send_word(w);
	endtask

	task automatic send_literal(input logic [4:0] n);
		brd_pkg::item_t w;
		w = random_word(brd_pkg::KIND_LITERAL);
		w.literal_bits = n;
		send_word(w);
	endtask

	task automatic send_push(input logic [7:0] b);
		brd_pkg::item_t w;
		w = random_word(brd_pkg::KIND_PUSH);
		w.data_byte = b;
		send_word(w);
	endtask

	// Sender pauses until every pending result has come back.
	task automatic wait_for_results();
		@(negedge clk);
		item_valid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Decoding straight out of reset, with a split that needs no new bits.
	task automatic test_decode_before_start();
		send_bool(8'd255);
	endtask

	// Extreme bytes, probabilities and literal sizes; runs the queue dry.
	task automatic test_field_extremes();
		send_push(8'hFF);
		send_push(8'h00);
		send_word(random_word(brd_pkg::KIND_START));
		send_bool(8'd0);
		send_bool(8'd255);
		send_literal(5'd0);
		send_literal(5'd16);
		send_literal(5'd31);
	endtask

	// One more push than the queue holds, then decode to see the flag.
	task automatic test_queue_full();
		for (int i = 0; i <= brd_pkg::QUEUE_DEPTH; i++)
			send_word(random_word(brd_pkg::KIND_PUSH));
		send_word(random_word(brd_pkg::KIND_START));
		send_bool(8'($urandom_range(0, 255)));
		wait_for_results();
	endtask

	// Result side holds off for a long stretch while words keep coming.
	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		hold_off = 400;
		for (int i = 0; i < 6; i++)
			send_word(random_word(brd_pkg::KIND_PUSH));
		send_word(random_word(brd_pkg::KIND_START));
		for (int i = 0; i < 24; i++)
			send_bool(8'($urandom_range(0, 255)));
		wait_for_results();
	endtask

	// Mostly well-formed streams: bytes, a start, then a run of decodes.
	task automatic test_random_streams();
		int r;
		int n;
		int lb;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			rx_gaps_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 9);
			if (r == 0) begin
				repeat (10)
					send_word(random_word(brd_pkg::kind_t'(2'($urandom_range(0, 3)))));
			end else if (r == 1) begin
				repeat (brd_pkg::QUEUE_DEPTH + 2) send_word(random_word(brd_pkg::KIND_PUSH));
			end else if (r == 2) begin
				send_word(random_word(brd_pkg::KIND_START));
				repeat ($urandom_range(1, 4)) send_bool(8'($urandom_range(0, 255)));
			end else begin
				n = $urandom_range(2, 10);
				repeat (n) send_word(random_word(brd_pkg::KIND_PUSH));
				send_word(random_word(brd_pkg::KIND_START));
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 9) < 7) begin
						send_bool(8'($urandom_range(0, 255)));
					end else begin
						lb = $urandom_range(0, 99);
						if (lb < 80) send_literal(5'($urandom_range(0, 8)));
						else if (lb < 95) send_literal(5'($urandom_range(9, 16)));
						else send_literal(5'($urandom_range(17, 31)));
					end
				end
			end
			if ($urandom_range(0, 11) == 0) wait_for_results();
		end
	endtask

	// Reset, then the tests in turn, then the final check.
	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		error_count = 0;
		cycle_count = 0;
		items_sent = 0;
		hold_off = 0;
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		range_q = brd_pkg::RANGE_INIT;
		window_q = '0;
		shift_byte_q = '0;
		shift_left_q = '0;
		fifo_head = 0;
		fifo_tail = 0;
		fifo_count = 0;
		underrun_q = 1'b0;
		overflow_q = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_decode_before_start();
		test_field_extremes();
		test_queue_full();
		test_backpressure();
		test_random_streams();

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/brd_pkg.sv
hw/rtl/brd_queue.sv
hw/rtl/brd_datapath.sv
hw/rtl/brd_ctrl.sv
hw/rtl/boolean_range_decoder_unit.sv
dv/tb_top.sv
